// ===== design/pcs_pkg.sv =====
`timescale 1ns / 1ps

package pcs_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PICK,
        S_QDIV,
        S_ROOT,
        S_MUL_LO,
        S_MUL_HI,
        S_TDIV,
        S_SCORE,
        S_FINISH
    } pcs_state_t;

    // field widths
    localparam int GAIN_W   = 20;
    localparam int COUNT_W  = 23;
    localparam int VLOSS_W  = 7;
    localparam int ACTION_W = 9;
    localparam int VSUM_W   = 40;
    localparam int PRIOR_W  = 17;
    localparam int SCORE_W  = 41;
    localparam int ROOT_W   = 20;

    // internal widths
    localparam int N_W    = 24;           // visits plus virtual loss
    localparam int SRC_W  = 41;           // shifting dividend / radicand
    localparam int REM_W  = 26;           // partial remainder
    localparam int GP_W   = 37;           // gain times prior
    localparam int MUL_W  = 47;           // gain-prior times half of the root
    localparam int PROD_W = 57;           // full product
    localparam int TERM_W = 33;           // product over 2^24, then quotient
    localparam int CNT_W  = 6;

    // iterations of the shared subtract unit
    localparam logic [CNT_W-1:0] Q_LAST    = 6'd40;
    localparam logic [CNT_W-1:0] ROOT_LAST = 6'd19;
    localparam logic [CNT_W-1:0] TERM_LAST = 6'd32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd92668;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

endpackage

// ===== design/puct_child_select.sv =====
`timescale 1ns / 1ps
// sequencing: one shared subtract unit steps a 41-step Q division, a 20-step root and a
//   33-step term division, with a pick step before each phase; the root runs only for a
//   group's first item, the Q division is skipped when n is zero, and an absent slot runs
//   no phase but the root
// flow: one item in flight; the next transfer is taken once the item is back in idle, later
//   while a closing item waits on a stalled result
// reset: rst_n asynchronous active low; gain back to its default, running best and root cleared

module puct_child_select
    import pcs_pkg::*;
#(
    parameter int NUM_ACTIONS = 362
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [GAIN_W-1:0]          cfg_data,
    // child slot channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [COUNT_W-1:0]         parent_visits,
    input  logic [VLOSS_W-1:0]         parent_virtual_loss,
    input  logic [ACTION_W-1:0]        action,
    input  logic                       child_present,
    input  logic [COUNT_W-1:0]         child_visits,
    input  logic [VLOSS_W-1:0]         child_virtual_loss,
    input  logic signed [VSUM_W-1:0]   child_value_sum,
    input  logic [PRIOR_W-1:0]         child_prior,
    input  logic                       last,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ACTION_W-1:0]        top_action,
    output logic                       found,
    output logic signed [SCORE_W-1:0]  top_score
);

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    pcs_state_t          state_reg, state_next;

    // control state
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [SCORE_W-1:0]  lead_score_reg, lead_score_next;
    logic [ACTION_W-1:0] lead_action_reg, lead_action_next;
    logic                any_found_reg, any_found_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic                group_open_reg, group_open_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    // outstanding work of the current item
    logic                q_todo_reg, q_todo_next;
    logic                root_todo_reg, root_todo_next;
    logic                mul_todo_reg, mul_todo_next;
    logic                tdiv_todo_reg, tdiv_todo_next;
    logic                score_todo_reg, score_todo_next;

    // payload
    logic [ACTION_W-1:0] action_reg, action_next;
    logic                last_reg, last_next;
    logic [N_W-1:0]      n_reg, n_next;
    logic [N_W-1:0]      ns_reg, ns_next;
    logic [SRC_W-1:0]    mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [GP_W-1:0]     gp_reg, gp_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SCORE_W-1:0]  q_reg, q_next;
    logic [TERM_W-1:0]   term_reg, term_next;
    // shared subtract unit
    logic [SRC_W-1:0]    src_reg, src_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [SRC_W-1:0]    quo_reg, quo_next;
    logic [N_W-1:0]      dvs_reg, dvs_next;
    // result register
    logic [ACTION_W-1:0] out_action_reg, out_action_next;
    logic                out_found_reg, out_found_next;
    logic [SCORE_W-1:0]  out_score_reg, out_score_next;

    // ---------------------------------------------------------------
    // control signals
    // ---------------------------------------------------------------
    logic in_take;
    logic out_free;
    logic out_load;
    logic step_done;
    logic gain_write;

    // ---------------------------------------------------------------
    // input decode
    // ---------------------------------------------------------------
    logic [N_W-1:0]   in_n;
    logic [N_W-1:0]   in_ns;
    logic [SRC_W-1:0] in_num;
    logic [SRC_W-1:0] in_mag;
    logic             in_scored;

    assign in_n   = {1'b0, child_visits} + {{(N_W-VLOSS_W){1'b0}}, child_virtual_loss};
    assign in_ns  = {1'b0, parent_visits} + {{(N_W-VLOSS_W){1'b0}}, parent_virtual_loss};
    // value sum less virtual loss, both with 16 fraction bits
    assign in_num = {child_value_sum[VSUM_W-1], child_value_sum}
                  - {{(SRC_W-VLOSS_W-16){1'b0}}, child_virtual_loss, 16'b0};
    assign in_mag = in_num[SRC_W-1] ? (~in_num + {{(SRC_W-1){1'b0}}, 1'b1}) : in_num;
    // slots beyond the action space count as absent
    assign in_scored = child_present
                     && ({{(32-ACTION_W){1'b0}}, action} < 32'(NUM_ACTIONS));

    // ---------------------------------------------------------------
    // shared subtract unit: one restoring step of a divide or a root
    // ---------------------------------------------------------------
    logic             root_mode;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] diff;
    logic             ge;

    assign root_mode = (state_reg == S_ROOT);
    // a root step takes two radicand bits, a divide step one
    assign rem_sh = root_mode ? {rem_reg[REM_W-3:0], src_reg[SRC_W-1:SRC_W-2]}
                              : {rem_reg[REM_W-2:0], src_reg[SRC_W-1]};
    // root trial is four times the partial root plus one
    assign trial  = root_mode ? {{(REM_W-ROOT_W-2){1'b0}}, quo_reg[ROOT_W-1:0], 2'b01}
                              : {{(REM_W-N_W){1'b0}}, dvs_reg};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    // ---------------------------------------------------------------
    // multiplier: gain-prior times one half of the root per cycle
    // ---------------------------------------------------------------
    logic [ROOT_W/2-1:0] mul_b;
    logic [MUL_W-1:0]    mul_p;

    assign mul_b = (state_reg == S_MUL_HI) ? root_reg[ROOT_W-1:ROOT_W/2]
                                           : root_reg[ROOT_W/2-1:0];
    assign mul_p = MUL_W'(gp_reg) * MUL_W'(mul_b);

    // ---------------------------------------------------------------
    // score: -Q plus term, saturated
    // ---------------------------------------------------------------
    logic [SCORE_W:0]   sum_wide;
    logic [SCORE_W-1:0] score_sat;
    logic               score_better;

    assign sum_wide = {{(SCORE_W+1-TERM_W){1'b0}}, term_reg} - {q_reg[SCORE_W-1], q_reg};

    always_comb
    begin
        if (sum_wide[SCORE_W] != sum_wide[SCORE_W-1])
        begin
            score_sat = sum_wide[SCORE_W] ? SCORE_MIN : SCORE_MAX;
        end
        else
        begin
            score_sat = sum_wide[SCORE_W-1:0];
        end
    end

    // strictly greater replaces; the first present child always wins
    assign score_better = !any_found_reg || ($signed(score_sat) > $signed(lead_score_reg));

    // ---------------------------------------------------------------
    // control outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        in_stall   = (state_reg != S_IDLE);
        in_take    = in_valid && (state_reg == S_IDLE);
        cfg_ready  = 1'b1;
        gain_write = cfg_valid && (cfg_data != '0);
        out_free   = !out_valid_reg || !out_stall;
        out_load   = (state_reg == S_FINISH) && last_reg && out_free;
        step_done  = ((state_reg == S_QDIV) && (cnt_reg == Q_LAST))
                  || ((state_reg == S_ROOT) && (cnt_reg == ROOT_LAST))
                  || ((state_reg == S_TDIV) && (cnt_reg == TERM_LAST));
    end

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                priority if (q_todo_reg)     state_next = S_QDIV;
                else if (root_todo_reg)      state_next = S_ROOT;
                else if (mul_todo_reg)       state_next = S_MUL_LO;
                else if (tdiv_todo_reg)      state_next = S_TDIV;
                else if (score_todo_reg)     state_next = S_SCORE;
                else                         state_next = S_FINISH;
            end
            S_QDIV, S_ROOT, S_TDIV:
            begin
                if (step_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_PICK;
            S_SCORE:  state_next = S_PICK;
            S_FINISH:
            begin
                // a closing item waits here while the previous result is not taken
                if (!last_reg || out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath
    // ---------------------------------------------------------------
    always_comb
    begin
        gain_next        = gain_reg;
        lead_score_next  = lead_score_reg;
        lead_action_next = lead_action_reg;
        any_found_next   = any_found_reg;
        root_next        = root_reg;
        group_open_next  = group_open_reg;
        out_valid_next   = out_valid_reg;
        cnt_next         = cnt_reg;
        q_todo_next      = q_todo_reg;
        root_todo_next   = root_todo_reg;
        mul_todo_next    = mul_todo_reg;
        tdiv_todo_next   = tdiv_todo_reg;
        score_todo_next  = score_todo_reg;
        action_next      = action_reg;
        last_next        = last_reg;
        n_next           = n_reg;
        ns_next          = ns_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        gp_next          = gp_reg;
        prod_next        = prod_reg;
        q_next           = q_reg;
        term_next        = term_reg;
        src_next         = src_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        dvs_next         = dvs_reg;
        out_action_next  = out_action_reg;
        out_found_next   = out_found_reg;
        out_score_next   = out_score_reg;

        // a write of zero leaves the gain alone
        if (gain_write)
        begin
            gain_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    action_next     = action;
                    last_next       = last;
                    n_next          = in_n;
                    ns_next         = in_ns;
                    mag_next        = in_mag;
                    neg_next        = in_num[SRC_W-1];
                    gp_next         = GP_W'(gain_reg) * GP_W'(child_prior);
                    q_next          = '0;
                    q_todo_next     = in_scored && (in_n != '0);
                    root_todo_next  = !group_open_reg;
                    mul_todo_next   = in_scored;
                    tdiv_todo_next  = in_scored;
                    score_todo_next = in_scored;
                    // first item of a group opens it
                    if (!group_open_reg)
                    begin
                        lead_score_next  = '0;
                        lead_action_next = '0;
                        any_found_next   = 1'b0;
                        group_open_next  = 1'b1;
                    end
                end
            end
            S_PICK:
            begin
                // load the shared unit for the phase about to run
                cnt_next = '0;
                rem_next = '0;
                quo_next = '0;
                priority if (q_todo_reg)
                begin
                    src_next = mag_reg;
                    dvs_next = n_reg;
                end
                else if (root_todo_reg)
                begin
                    // radicand is parent count with 16 fraction bits
                    src_next = {ns_reg, 16'b0, 1'b0};
                end
                else if (mul_todo_reg)
                begin
                    cnt_next = '0;
                end
                else if (tdiv_todo_reg)
                begin
                    // drop the 24 low product bits before dividing by 1 + n
                    src_next = {prod_reg[PROD_W-1:PROD_W-TERM_W], {(SRC_W-TERM_W){1'b0}}};
                    dvs_next = n_reg + {{(N_W-1){1'b0}}, 1'b1};
                end
                else
                begin
                    cnt_next = '0;
                end
            end
            S_QDIV, S_ROOT, S_TDIV:
            begin
                src_next = root_mode ? {src_reg[SRC_W-3:0], 2'b00} : {src_reg[SRC_W-2:0], 1'b0};
                rem_next = ge ? diff : rem_sh;
                quo_next = {quo_reg[SRC_W-2:0], ge};
                cnt_next = cnt_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                if (step_done)
                begin
                    if (state_reg == S_QDIV)
                    begin
                        // truncation toward zero: divide magnitudes, restore sign
                        q_next      = neg_reg ? (~quo_next + {{(SRC_W-1){1'b0}}, 1'b1})
                                              : quo_next;
                        q_todo_next = 1'b0;
                    end
                    else if (state_reg == S_ROOT)
                    begin
                        root_next      = quo_next[ROOT_W-1:0];
                        root_todo_next = 1'b0;
                    end
                    else
                    begin
                        term_next      = quo_next[TERM_W-1:0];
                        tdiv_todo_next = 1'b0;
                    end
                end
            end
            S_MUL_LO:
            begin
                prod_next = PROD_W'(mul_p);
            end
            S_MUL_HI:
            begin
                prod_next     = prod_reg + (PROD_W'(mul_p) << (ROOT_W / 2));
                mul_todo_next = 1'b0;
            end
            S_SCORE:
            begin
                if (score_better)
                begin
                    lead_score_next  = score_sat;
                    lead_action_next = action_reg;
                    any_found_next   = 1'b1;
                end
                score_todo_next = 1'b0;
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    // lead regs stay zero for a group with no child
                    out_action_next = lead_action_reg;
                    out_found_next  = any_found_reg;
                    out_score_next  = lead_score_reg;
                    out_valid_next  = 1'b1;
                    group_open_next = 1'b0;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // register update
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            gain_reg        <= GAIN_RESET;
            lead_score_reg  <= '0;
            lead_action_reg <= '0;
            any_found_reg   <= 1'b0;
            root_reg        <= '0;
            group_open_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            q_todo_reg      <= 1'b0;
            root_todo_reg   <= 1'b0;
            mul_todo_reg    <= 1'b0;
            tdiv_todo_reg   <= 1'b0;
            score_todo_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            gain_reg        <= gain_next;
            lead_score_reg  <= lead_score_next;
            lead_action_reg <= lead_action_next;
            any_found_reg   <= any_found_next;
            root_reg        <= root_next;
            group_open_reg  <= group_open_next;
            out_valid_reg   <= out_valid_next;
            cnt_reg         <= cnt_next;
            q_todo_reg      <= q_todo_next;
            root_todo_reg   <= root_todo_next;
            mul_todo_reg    <= mul_todo_next;
            tdiv_todo_reg   <= tdiv_todo_next;
            score_todo_reg  <= score_todo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        last_reg       <= last_next;
        n_reg          <= n_next;
        ns_reg         <= ns_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        gp_reg         <= gp_next;
        prod_reg       <= prod_next;
        q_reg          <= q_next;
        term_reg       <= term_next;
        src_reg        <= src_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        dvs_reg        <= dvs_next;
        out_action_reg <= out_action_next;
        out_found_reg  <= out_found_next;
        out_score_reg  <= out_score_next;
    end

    // result ports
    assign out_valid  = out_valid_reg;
    assign top_action = out_action_reg;
    assign found      = out_found_reg;
    assign top_score  = $signed(out_score_reg);

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // a result only appears out of the closing step
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside the closing step");

    // restoring division keeps the partial remainder below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_QDIV) || (state_reg == S_TDIV)) |-> (rem_reg < {2'b00, dvs_reg}))
        else $error("partial remainder not below divisor");

    // scoring only once every phase before it is done
    a_score_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCORE) |-> (!q_todo_reg && !root_todo_reg && !mul_todo_reg
                                    && !tdiv_todo_reg))
        else $error("score taken before its operands");

    // an empty group reports a zero action and score
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> ((out_action_reg == '0) && (out_score_reg == '0)))
        else $error("empty group with nonzero result");

    // the gain never holds zero
    a_gain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg != '0)
        else $error("exploration gain is zero");

endmodule

// ===== dv/child_select_checker.sv =====
`timescale 1ns / 1ps

module child_select_checker
    import pcs_pkg::*;
#(
    parameter int NUM_ACTIONS = 362
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [GAIN_W-1:0]          cfg_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [COUNT_W-1:0]         parent_visits,
    input  logic [VLOSS_W-1:0]         parent_virtual_loss,
    input  logic [ACTION_W-1:0]        action,
    input  logic                       child_present,
    input  logic [COUNT_W-1:0]         child_visits,
    input  logic [VLOSS_W-1:0]         child_virtual_loss,
    input  logic signed [VSUM_W-1:0]   child_value_sum,
    input  logic [PRIOR_W-1:0]         child_prior,
    input  logic                       last,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [ACTION_W-1:0]        top_action,
    input  logic                       found,
    input  logic signed [SCORE_W-1:0]  top_score,
    output int                         fail_count,
    output int                         pending_count
);

    localparam longint SAT_HI = (longint'(1) << (SCORE_W - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) << (SCORE_W - 1));
    localparam int     PRINT_CAP = 100;

    typedef struct {
        logic [ACTION_W-1:0]       act;
        logic                      hit;
        logic signed [SCORE_W-1:0] score;
    } best_child_t;

    best_child_t expected_best[$];

    logic [GAIN_W-1:0]   gain;
    longint              lead_score;
    logic [ACTION_W-1:0] lead_action;
    logic                any_child;
    logic [ROOT_W-1:0]   parent_root;
    logic                in_group;

    task automatic report(input string what);
        if (fail_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // floor of the square root, one bit at a time from the top
    function automatic logic [ROOT_W-1:0] root_of(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        for (int k = 31; k >= 0; k--)
        begin
            b = r | (64'd1 << k);
            if (b * b <= x)
                r = b;
        end
        return r[ROOT_W-1:0];
    endfunction

    // scores one accepted slot and queues the group's best on its last slot
    task automatic score_child();
        logic [63:0] n;
        logic [63:0] prod;
        logic [63:0] term;
        longint      num;
        longint      q;
        longint      sc;
        best_child_t res;
        if (!in_group)
        begin
            parent_root = root_of((64'(parent_visits) + 64'(parent_virtual_loss)) << 16);
            lead_score  = 0;
            lead_action = '0;
            any_child   = 1'b0;
            in_group    = 1'b1;
        end
        if (child_present && action < NUM_ACTIONS)
        begin
            n = 64'(child_visits) + 64'(child_virtual_loss);
            q = 0;
            if (n != 0)
            begin
                num = longint'(child_value_sum) - longint'(64'(child_virtual_loss) << 16);
                q = num / longint'(n);
            end
            prod = 64'(gain) * 64'(child_prior) * 64'(parent_root);
            term = (prod / (n + 64'd1)) >> 24;
            sc = longint'(term) - q;
            if (sc > SAT_HI)
                sc = SAT_HI;
            else if (sc < SAT_LO)
                sc = SAT_LO;
            if (!any_child || sc > lead_score)
            begin
                lead_score  = sc;
                lead_action = action;
                any_child   = 1'b1;
            end
        end
        if (last)
        begin
            in_group  = 1'b0;
            res.act   = any_child ? lead_action : '0;
            res.hit   = any_child;
            res.score = any_child ? lead_score[SCORE_W-1:0] : '0;
            expected_best.push_back(res);
        end
    endtask

    task automatic check_result();
        best_child_t want;
        if (expected_best.size() == 0)
            report($sformatf("result with nothing pending, action %0d", top_action));
        else
        begin
            want = expected_best.pop_front();
            if (found !== want.hit)
                report($sformatf("found %b, want %b", found, want.hit));
            if (top_action !== want.act)
                report($sformatf("top_action %0d, want %0d", top_action, want.act));
            if (top_score !== want.score)
                report($sformatf("top_score %0d, want %0d", top_score, want.score));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain        = GAIN_RESET;
            lead_score  = 0;
            lead_action = '0;
            any_child   = 1'b0;
            parent_root = '0;
            in_group    = 1'b0;
            expected_best.delete();
            pending_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_data != '0)
                gain = cfg_data;
            if (in_valid && !in_stall)
                score_child();
            if (out_valid && !out_stall)
                check_result();
            pending_count = expected_best.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pcs_pkg::*;

    localparam int NUM_ACTIONS  = 362;
    localparam int ACTION_TOP   = 511;          // largest value the action field carries
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 150;          // covers the slowest item in flight
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_SLOTS  = 150;          // slots offered per random phase, at least

    localparam logic [GAIN_W-1:0]        GAIN_TOP  = '1;
    localparam logic [GAIN_W-1:0]        GAIN_ONE  = 20'd1;
    localparam logic [GAIN_W-1:0]        GAIN_NONE = '0;
    localparam logic [COUNT_W-1:0]       COUNT_MAX = '1;
    localparam logic [VLOSS_W-1:0]       VLOSS_MAX = '1;
    localparam logic [PRIOR_W-1:0]       PRIOR_MAX = '1;
    localparam logic signed [VSUM_W-1:0] VSUM_MAX  = {1'b0, {(VSUM_W-1){1'b1}}};
    localparam logic signed [VSUM_W-1:0] VSUM_MIN  = {1'b1, {(VSUM_W-1){1'b0}}};

    // one child slot as the sender offers it
    typedef struct {
        logic [COUNT_W-1:0]       pv;
        logic [VLOSS_W-1:0]       pvl;
        logic [ACTION_W-1:0]      act;
        logic                     present;
        logic [COUNT_W-1:0]       cv;
        logic [VLOSS_W-1:0]       cvl;
        logic signed [VSUM_W-1:0] vsum;
        logic [PRIOR_W-1:0]       prior;
        logic                     is_last;
    } child_slot_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [GAIN_W-1:0]         cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [COUNT_W-1:0]        parent_visits;
    logic [VLOSS_W-1:0]        parent_virtual_loss;
    logic [ACTION_W-1:0]       action;
    logic                      child_present;
    logic [COUNT_W-1:0]        child_visits;
    logic [VLOSS_W-1:0]        child_virtual_loss;
    logic signed [VSUM_W-1:0]  child_value_sum;
    logic [PRIOR_W-1:0]        child_prior;
    logic                      last;
    logic                      out_valid;
    logic                      out_stall;
    logic [ACTION_W-1:0]       top_action;
    logic                      found;
    logic signed [SCORE_W-1:0] top_score;
    int                        fail_count;
    int                        pending_count;

    // slots left in the current sender burst
    int burst_left = 0;

    puct_child_select #(.NUM_ACTIONS(NUM_ACTIONS)) u_dut (.*);

    // watches all three channels, predicts the best child and compares
    child_select_checker #(.NUM_ACTIONS(NUM_ACTIONS)) u_checker (.*);

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case the block hangs or drops a result
    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // random field values, weighted towards the corners
    // ------------------------------------------------------------------

    function automatic logic [COUNT_W-1:0] rand_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COUNT_MAX;
            2, 3:    return COUNT_W'($urandom);
            4, 5, 6: return COUNT_W'($urandom_range(0, 5000));
            default: return COUNT_W'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [VLOSS_W-1:0] rand_vloss();
        case ($urandom_range(0, 9))
            0:       return VLOSS_MAX;
            1:       return VLOSS_W'($urandom);
            2, 3:    return VLOSS_W'($urandom_range(0, 64));
            default: return VLOSS_W'($urandom_range(0, 6));
        endcase
    endfunction

    // value sums mostly within plus or minus one per visit, sometimes anywhere
    function automatic logic signed [VSUM_W-1:0] rand_vsum(input longint n);
        logic [63:0] r;
        longint      span;
        case ($urandom_range(0, 9))
            0:       return VSUM_MAX;
            1:       return VSUM_MIN;
            2, 3:    return VSUM_W'({$urandom, $urandom});
            default:
            begin
                span = n * 65536;
                r = {$urandom, $urandom};
                return VSUM_W'(longint'(r % (64'(span) * 2 + 64'd1)) - span);
            end
        endcase
    endfunction

    function automatic logic [PRIOR_W-1:0] rand_prior();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PRIOR_W'(65536);
            2:       return PRIOR_MAX;
            3:       return PRIOR_W'($urandom);
            default: return PRIOR_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic child_slot_t slot_of(
        input logic [COUNT_W-1:0]       pv,
        input logic [VLOSS_W-1:0]       pvl,
        input logic [ACTION_W-1:0]      act,
        input logic                     present,
        input logic [COUNT_W-1:0]       cv,
        input logic [VLOSS_W-1:0]       cvl,
        input logic signed [VSUM_W-1:0] vsum,
        input logic [PRIOR_W-1:0]       prior,
        input logic                     is_last
    );
        child_slot_t s;
        s.pv      = pv;
        s.pvl     = pvl;
        s.act     = act;
        s.present = present;
        s.cv      = cv;
        s.cvl     = cvl;
        s.vsum    = vsum;
        s.prior   = prior;
        s.is_last = is_last;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // sender side: called at a falling edge, returns at a falling edge
    // ------------------------------------------------------------------

    // offers one slot; a new burst may open with a gap, otherwise valid stays high
    task automatic push_slot(input child_slot_t s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        parent_visits       <= s.pv;
        parent_virtual_loss <= s.pvl;
        action              <= s.act;
        child_present       <= s.present;
        child_visits        <= s.cv;
        child_virtual_loss  <= s.cvl;
        child_value_sum     <= s.vsum;
        child_prior         <= s.prior;
        last                <= s.is_last;
        in_valid            <= 1'b1;
        // payload holds until the transfer
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // sender goes quiet until every pending result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (pending_count != 0);
    endtask

    // gain write only once the block is idle: drained and past its latency
    task automatic write_gain(input logic [GAIN_W-1:0] g);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_data  <= g;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one parent's worth of slots; most groups ascend, some are broken on purpose
    task automatic random_group(output int slots);
        child_slot_t s;
        int          len;
        int          act;
        int          style;
        style  = $urandom_range(0, 19);
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        act    = (style == 19) ? $urandom_range(340, ACTION_TOP) : $urandom_range(0, 60);
        slots  = 0;
        for (int k = 0; k < len; k++)
        begin
            // parent fields only matter on the first slot, the rest are noise
            s.pv      = (k == 0) ? rand_count() : COUNT_W'($urandom);
            s.pvl     = (k == 0) ? rand_vloss() : VLOSS_W'($urandom);
            s.act     = ACTION_W'(act);
            // style 17: group with no child at all
            s.present = (style == 17) ? 1'b0 : ($urandom_range(0, 4) != 0);
            s.cv      = rand_count();
            s.cvl     = rand_vloss();
            s.vsum    = rand_vsum(longint'(s.cv) + longint'(s.cvl));
            s.prior   = rand_prior();
            s.is_last = (k == len - 1);
            push_slot(s);
            slots++;
            // style 18: descending actions
            if (style == 18)
                act = act - int'($urandom_range(1, 30));
            else
                act = act + int'($urandom_range(1, 40));
            if (act < 0)
                act = 0;
            if (act > ACTION_TOP)
                act = ACTION_TOP;
        end
    endtask

    task automatic run_phase(input logic [GAIN_W-1:0] g);
        int slots;
        int total;
        write_gain(g);
        total = 0;
        while (total < PHASE_SLOTS)
        begin
            random_group(slots);
            total += slots;
            // now and then the sender pauses for a full drain
            if ($urandom_range(0, 24) == 0)
                wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // receiver side: stall pattern of its own, with two long hold-offs
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int rx_cycles;
        int seg_mode;
        int seg_len;
        int next_hold;
        int holds_done;
        rx_cycles  = 0;
        next_hold  = 3000;
        holds_done = 0;
        out_stall  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            // hold off long enough that the block fills and stalls its input
            if (holds_done < 2 && rx_cycles >= next_hold)
            begin
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                    rx_cycles++;
                end
                holds_done++;
                next_hold = rx_cycles + 50000;
            end
            seg_mode = $urandom_range(0, 3);
            seg_len  = $urandom_range(20, 300);
            repeat (seg_len)
            begin
                @(negedge clk);
                rx_cycles++;
                case (seg_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ((rx_cycles % 9) < 4);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        cfg_valid           = 1'b0;
        cfg_data            = '0;
        in_valid            = 1'b0;
        parent_visits       = '0;
        parent_virtual_loss = '0;
        action              = '0;
        child_present       = 1'b0;
        child_visits        = '0;
        child_virtual_loss  = '0;
        child_value_sum     = '0;
        child_prior         = '0;
        last                = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, gain at its reset value
        // single slot group, every count zero so no visits and no root
        push_slot(slot_of(0, 0, 0, 1, 0, 0, 0, 0, 1));
        // group with no child present
        push_slot(slot_of(100, 3, 4, 0, 5, 1, 65536, 30000, 0));
        push_slot(slot_of(9, 9, 9, 0, 9, 9, -65536, 9, 1));
        // actions past the end of the board count as absent
        push_slot(slot_of(50, 0, 362, 1, 2, 0, 131072, 40000, 0));
        push_slot(slot_of(50, 0, ACTION_TOP, 1, 0, 0, 0, 65536, 1));
        // field extremes; parent fields on later slots must be ignored
        push_slot(slot_of(COUNT_MAX, VLOSS_MAX, 0, 1, 0, 0, VSUM_MAX, PRIOR_MAX, 0));
        push_slot(slot_of(0, 0, 7, 1, COUNT_MAX, VLOSS_MAX, VSUM_MIN, 0, 0));
        push_slot(slot_of(COUNT_MAX, VLOSS_MAX, 200, 1, 1, 0, VSUM_MIN, PRIOR_MAX, 0));
        push_slot(slot_of(1, 1, 361, 1, 1, VLOSS_MAX, VSUM_MAX, 65536, 1));
        // equal scores, the earlier action keeps the lead
        push_slot(slot_of(400, 0, 10, 1, 20, 2, 655360, 20000, 0));
        push_slot(slot_of(0, 0, 20, 1, 20, 2, 655360, 20000, 1));
        // later child strictly better, absent slot between, absent last slot
        push_slot(slot_of(1000, 10, 1, 1, 100, 0, 6553600, 1000, 0));
        push_slot(slot_of(1000, 10, 2, 0, 0, 0, 0, 65536, 0));
        push_slot(slot_of(1000, 10, 3, 1, 10, 0, -3276800, 50000, 0));
        push_slot(slot_of(1000, 10, 4, 0, 1, 1, 0, 0, 1));
        // first present child scores below zero and still leads
        push_slot(slot_of(16, 0, 30, 1, 4, 0, 262144, 0, 0));
        push_slot(slot_of(16, 0, 31, 1, 4, 0, 524288, 0, 1));

        // random phases over the gain range; a zero write must leave gain at one
        run_phase(GAIN_TOP);
        run_phase(GAIN_ONE);
        run_phase(GAIN_NONE);
        run_phase(GAIN_W'($urandom_range(2, 1048574)));
        run_phase(GAIN_RESET);

        // let everything drain, then allow for the block's latency
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pcs_pkg.sv
design/puct_child_select.sv
dv/child_select_checker.sv
dv/tb.sv
